// File: rtl/core/pan_tilt_servo_smoother_defines.svh
// assertion macros used by the checker file of the pan/tilt smoother
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef PAN_TILT_SERVO_SMOOTHER_DEFINES_SVH
`define PAN_TILT_SERVO_SMOOTHER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define PTS_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("pan_tilt_servo_smoother: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define PTS_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("pan_tilt_servo_smoother: next-cycle check failed");

// next-cycle implication that also holds across reset
`define PTS_ASSERT_RESET(label, cond, prop) \
    label: assert property (@(posedge i_clk) (cond) |=> (prop)) \
        else $error("pan_tilt_servo_smoother: reset check failed");

`endif

// File: rtl/core/pts_pkg.sv
// shared types, codes, reset values and helper functions of the pan/tilt smoother
// no dependencies; used by pts_blend and pan_tilt_servo_smoother
package pts_pkg;

    // reset values
    localparam logic [7:0]  START_STEP       = 8'd1;
    localparam logic [7:0]  RESET_ANGLE      = 8'd90;
    localparam logic [15:0] RESET_SMOOTH     = 16'd23040;
    localparam logic [7:0]  RESET_PAN_LIMIT  = 8'd180;
    localparam logic [7:0]  RESET_TILT_LOW   = 8'd0;
    localparam logic [7:0]  RESET_TILT_HIGH  = 8'd180;
    localparam logic [7:0]  RESET_STEP_LOW   = 8'd1;
    localparam logic [7:0]  RESET_STEP_HIGH  = 8'd10;
    localparam logic [7:0]  RESET_CENTRE     = 8'd90;
    localparam logic [8:0]  RESET_NEW_WEIGHT = 9'd64;
    localparam logic [8:0]  RESET_OLD_WEIGHT = 9'd192;

    // command codes
    typedef enum logic [3:0] {
        CMD_TICK       = 4'd0,
        CMD_SET_PAN    = 4'd1,
        CMD_SET_TILT   = 4'd2,
        CMD_SET_BOTH   = 4'd3,
        CMD_PAN_UP     = 4'd4,
        CMD_PAN_DOWN   = 4'd5,
        CMD_TILT_UP    = 4'd6,
        CMD_TILT_DOWN  = 4'd7,
        CMD_STEP_UP    = 4'd8,
        CMD_STEP_DOWN  = 4'd9,
        CMD_HOME       = 4'd10,
        CMD_STORE_HOME = 4'd11,
        CMD_REINIT     = 4'd12
    } t_cmd;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_PAN_LIMIT  = 3'd0,
        REG_TILT_LOW   = 3'd1,
        REG_TILT_HIGH  = 3'd2,
        REG_STEP_LOW   = 3'd3,
        REG_STEP_HIGH  = 3'd4,
        REG_CENTRE     = 3'd5,
        REG_NEW_WEIGHT = 3'd6,
        REG_OLD_WEIGHT = 3'd7
    } t_cfg_reg;

    // smoothing weights, Q1.8
    typedef struct packed {
        logic [8:0] new_w;
        logic [8:0] old_w;
    } t_weights;

    // one result transaction
    typedef struct packed {
        logic [7:0] pan_target;
        logic [7:0] tilt_target;
        logic [7:0] step_now;
        logic [7:0] pan_home;
        logic [7:0] tilt_home;
        logic [7:0] pan_drive;
        logic [7:0] tilt_drive;
        logic       drive_valid;
    } t_result;

    // pan range check
    function automatic logic pan_fits(input logic [7:0] v, input logic [7:0] limit);
        return v <= limit;
    endfunction

    // tilt range check, empty when low is above high
    function automatic logic tilt_fits(input logic [7:0] v, input logic [7:0] lo,
                                       input logic [7:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    // Q8.8 to angle, round half up, saturate at 255
    function automatic logic [7:0] drive_of(input logic [15:0] s);
        logic [16:0] sum;
        sum = {1'b0, s} + 17'd128;
        return sum[16] ? 8'hFF : sum[15:8];
    endfunction

endpackage

// File: rtl/core/pts_blend.sv
// exponential smoothing step for one axis: Q8.8 position blended toward a target
// depends on pts_pkg (t_weights)
module pts_blend (
    input  logic [7:0]          i_goal,
    input  logic [15:0]         i_smooth,
    input  pts_pkg::t_weights   i_weights,
    output logic [15:0]         o_smooth
);

    logic [16:0] w_new_prod;
    logic [24:0] w_old_prod;
    logic [26:0] w_sum;
    logic [18:0] w_shifted;

    // two short products, no chaining
    assign w_new_prod = 17'(i_goal) * 17'(i_weights.new_w);
    assign w_old_prod = 25'(i_smooth) * 25'(i_weights.old_w);

    // sum with half-lsb rounding, then back to Q8.8
    assign w_sum     = 27'({w_new_prod, 8'h00}) + 27'(w_old_prod) + 27'd128;
    assign w_shifted = w_sum[26:8];

    // saturate at full scale
    assign o_smooth = (|w_shifted[18:16]) ? 16'hFFFF : w_shifted[15:0];

endmodule

// File: rtl/core/pan_tilt_servo_smoother.sv
// top level of the pan/tilt servo target keeper with exponential smoothing
// depends on pts_pkg and pts_blend
//
// channel   direction  handshake            payload
// input     in         i_valid / o_stall    i_cmd, i_angle
// result    out        o_valid / i_stall    o_pan_target .. o_drive_valid
// config    in         i_cfg_wr_en          i_cfg_index, i_cfg_data
//
// one transaction per cycle sustained while i_stall is low; path is input register,
// then one pass of command logic and the two blend multipliers into the result register
// a two-entry result buffer (output register plus skid) keeps input flowing while
// a result waits; o_stall rises only when both entries are full
// reset is synchronous, active low, and clears control and state to defaults
module pan_tilt_servo_smoother (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_cmd,
    input  logic [7:0]  i_angle,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_pan_target,
    output logic [7:0]  o_tilt_target,
    output logic [7:0]  o_step_now,
    output logic [7:0]  o_pan_home,
    output logic [7:0]  o_tilt_home,
    output logic [7:0]  o_pan_drive,
    output logic [7:0]  o_tilt_drive,
    output logic        o_drive_valid
);

    // config registers
    logic [7:0] r_pan_limit, r_tilt_low, r_tilt_high, r_step_low, r_step_high, r_centre;
    logic [8:0] r_new_weight, r_old_weight;

    // state
    logic [7:0]  r_pan_goal, r_tilt_goal, r_step, r_pan_rest, r_tilt_rest;
    logic [15:0] r_pan_smooth, r_tilt_smooth;
    logic [7:0]  n_pan_goal, n_tilt_goal, n_step, n_pan_rest, n_tilt_rest;
    logic [15:0] n_pan_smooth, n_tilt_smooth;
    logic        n_drive_valid;

    // input register
    logic       r_a_valid;
    logic [3:0] r_a_cmd;
    logic [7:0] r_a_angle;

    // result buffer
    logic              r_o_valid, r_skid_valid;
    pts_pkg::t_result  r_out, r_skid, n_result;

    logic              w_in_acc, w_a_move, w_out_take;
    pts_pkg::t_weights w_weights;
    logic [15:0]       w_pan_blend, w_tilt_blend;
    logic [7:0]        w_pan_up, w_pan_down, w_tilt_up, w_tilt_down;

    // handshake
    assign o_stall    = r_a_valid && r_skid_valid;
    assign w_in_acc   = i_valid && !o_stall;
    assign w_a_move   = r_a_valid && !r_skid_valid;
    assign w_out_take = r_o_valid && !i_stall;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan_limit  <= pts_pkg::RESET_PAN_LIMIT;
            r_tilt_low   <= pts_pkg::RESET_TILT_LOW;
            r_tilt_high  <= pts_pkg::RESET_TILT_HIGH;
            r_step_low   <= pts_pkg::RESET_STEP_LOW;
            r_step_high  <= pts_pkg::RESET_STEP_HIGH;
            r_centre     <= pts_pkg::RESET_CENTRE;
            r_new_weight <= pts_pkg::RESET_NEW_WEIGHT;
            r_old_weight <= pts_pkg::RESET_OLD_WEIGHT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                pts_pkg::REG_PAN_LIMIT:  r_pan_limit  <= i_cfg_data[7:0];
                pts_pkg::REG_TILT_LOW:   r_tilt_low   <= i_cfg_data[7:0];
                pts_pkg::REG_TILT_HIGH:  r_tilt_high  <= i_cfg_data[7:0];
                pts_pkg::REG_STEP_LOW:   r_step_low   <= i_cfg_data[7:0];
                pts_pkg::REG_STEP_HIGH:  r_step_high  <= i_cfg_data[7:0];
                pts_pkg::REG_CENTRE:     r_centre     <= i_cfg_data[7:0];
                pts_pkg::REG_NEW_WEIGHT: r_new_weight <= i_cfg_data;
                pts_pkg::REG_OLD_WEIGHT: r_old_weight <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_a_valid <= 1'b1;
        end else if (w_a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a_cmd   <= i_cmd;
            r_a_angle <= i_angle;
        end
    end

    // blend units
    assign w_weights.new_w = r_new_weight;
    assign w_weights.old_w = r_old_weight;

    pts_blend u_pan_blend (
        .i_goal    (r_pan_goal),
        .i_smooth  (r_pan_smooth),
        .i_weights (w_weights),
        .o_smooth  (w_pan_blend)
    );

    pts_blend u_tilt_blend (
        .i_goal    (r_tilt_goal),
        .i_smooth  (r_tilt_smooth),
        .i_weights (w_weights),
        .o_smooth  (w_tilt_blend)
    );

    // stepped targets, wrapping mod 256
    assign w_pan_up    = r_pan_goal + r_step;
    assign w_pan_down  = r_pan_goal - r_step;
    assign w_tilt_up   = r_tilt_goal + r_step;
    assign w_tilt_down = r_tilt_goal - r_step;

    // command decode and next state
    always_comb begin
        n_pan_goal    = r_pan_goal;
        n_tilt_goal   = r_tilt_goal;
        n_step        = r_step;
        n_pan_rest    = r_pan_rest;
        n_tilt_rest   = r_tilt_rest;
        n_pan_smooth  = r_pan_smooth;
        n_tilt_smooth = r_tilt_smooth;
        n_drive_valid = 1'b0;
        case (r_a_cmd)
            pts_pkg::CMD_TICK: begin
                n_pan_smooth  = w_pan_blend;
                n_tilt_smooth = w_tilt_blend;
                n_drive_valid = 1'b1;
            end
            pts_pkg::CMD_SET_PAN: begin
                if (pts_pkg::pan_fits(r_a_angle, r_pan_limit)) n_pan_goal = r_a_angle;
            end
            pts_pkg::CMD_SET_TILT: begin
                if (pts_pkg::tilt_fits(r_a_angle, r_tilt_low, r_tilt_high))
                    n_tilt_goal = r_a_angle;
            end
            pts_pkg::CMD_SET_BOTH: begin
                if (pts_pkg::pan_fits(r_a_angle, r_pan_limit)) n_pan_goal = r_a_angle;
                if (pts_pkg::tilt_fits(r_a_angle, r_tilt_low, r_tilt_high))
                    n_tilt_goal = r_a_angle;
            end
            pts_pkg::CMD_PAN_UP: begin
                if (pts_pkg::pan_fits(w_pan_up, r_pan_limit)) n_pan_goal = w_pan_up;
            end
            pts_pkg::CMD_PAN_DOWN: begin
                if (pts_pkg::pan_fits(w_pan_down, r_pan_limit)) n_pan_goal = w_pan_down;
            end
            pts_pkg::CMD_TILT_UP: begin
                if (pts_pkg::tilt_fits(w_tilt_up, r_tilt_low, r_tilt_high))
                    n_tilt_goal = w_tilt_up;
            end
            pts_pkg::CMD_TILT_DOWN: begin
                if (pts_pkg::tilt_fits(w_tilt_down, r_tilt_low, r_tilt_high))
                    n_tilt_goal = w_tilt_down;
            end
            pts_pkg::CMD_STEP_UP: begin
                if (r_step < r_step_high) n_step = r_step + 8'd1;
            end
            pts_pkg::CMD_STEP_DOWN: begin
                if (r_step > r_step_low) n_step = r_step - 8'd1;
            end
            pts_pkg::CMD_HOME: begin
                if (pts_pkg::pan_fits(r_pan_rest, r_pan_limit)) n_pan_goal = r_pan_rest;
                if (pts_pkg::tilt_fits(r_tilt_rest, r_tilt_low, r_tilt_high))
                    n_tilt_goal = r_tilt_rest;
            end
            pts_pkg::CMD_STORE_HOME: begin
                n_pan_rest  = r_pan_goal;
                n_tilt_rest = r_tilt_goal;
            end
            pts_pkg::CMD_REINIT: begin
                n_pan_smooth  = {r_centre, 8'h00};
                n_tilt_smooth = {r_centre, 8'h00};
                if (pts_pkg::pan_fits(r_centre, r_pan_limit)) n_pan_goal = r_centre;
                if (pts_pkg::tilt_fits(r_centre, r_tilt_low, r_tilt_high))
                    n_tilt_goal = r_centre;
                n_step      = pts_pkg::START_STEP;
                n_pan_rest  = r_centre;
                n_tilt_rest = r_centre;
            end
            default: begin
            end
        endcase
    end

    // result of this transaction
    always_comb begin
        n_result.pan_target  = n_pan_goal;
        n_result.tilt_target = n_tilt_goal;
        n_result.step_now    = n_step;
        n_result.pan_home    = n_pan_rest;
        n_result.tilt_home   = n_tilt_rest;
        n_result.pan_drive   = pts_pkg::drive_of(n_pan_smooth);
        n_result.tilt_drive  = pts_pkg::drive_of(n_tilt_smooth);
        n_result.drive_valid = n_drive_valid;
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan_goal    <= pts_pkg::RESET_ANGLE;
            r_tilt_goal   <= pts_pkg::RESET_ANGLE;
            r_step        <= pts_pkg::START_STEP;
            r_pan_rest    <= pts_pkg::RESET_ANGLE;
            r_tilt_rest   <= pts_pkg::RESET_ANGLE;
            r_pan_smooth  <= pts_pkg::RESET_SMOOTH;
            r_tilt_smooth <= pts_pkg::RESET_SMOOTH;
        end else if (w_a_move) begin
            r_pan_goal    <= n_pan_goal;
            r_tilt_goal   <= n_tilt_goal;
            r_step        <= n_step;
            r_pan_rest    <= n_pan_rest;
            r_tilt_rest   <= n_tilt_rest;
            r_pan_smooth  <= n_pan_smooth;
            r_tilt_smooth <= n_tilt_smooth;
        end
    end

    // result buffer control: output register first, skid when it is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid    <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_a_move) begin
                if (!r_o_valid || w_out_take) begin
                    r_o_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (w_out_take) begin
                r_o_valid    <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    // result buffer payload
    always_ff @(posedge i_clk) begin
        if (w_a_move) begin
            if (!r_o_valid || w_out_take) begin
                r_out <= n_result;
            end else begin
                r_skid <= n_result;
            end
        end else if (w_out_take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    // outputs
    assign o_valid       = r_o_valid;
    assign o_pan_target  = r_out.pan_target;
    assign o_tilt_target = r_out.tilt_target;
    assign o_step_now    = r_out.step_now;
    assign o_pan_home    = r_out.pan_home;
    assign o_tilt_home   = r_out.tilt_home;
    assign o_pan_drive   = r_out.pan_drive;
    assign o_tilt_drive  = r_out.tilt_drive;
    assign o_drive_valid = r_out.drive_valid;

endmodule

// File: rtl/core/pts_checker.sv
// port-level checks of the pan/tilt smoother, bound to the top level
// depends on pan_tilt_servo_smoother_defines.svh and pan_tilt_servo_smoother
`include "pan_tilt_servo_smoother_defines.svh"

module pts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_pan_target,
    input logic [7:0]  o_tilt_target,
    input logic [7:0]  o_step_now,
    input logic [7:0]  o_pan_home,
    input logic [7:0]  o_tilt_home,
    input logic [7:0]  o_pan_drive,
    input logic [7:0]  o_tilt_drive,
    input logic        o_drive_valid
);

    // result payload as one word
    logic [56:0] w_payload;

    assign w_payload = {o_pan_target, o_tilt_target, o_step_now, o_pan_home, o_tilt_home,
                        o_pan_drive, o_tilt_drive, o_drive_valid};

    // a held result keeps its payload
    `PTS_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(w_payload))

    // input stalls only while a result waits
    `PTS_ASSERT_NOW(a_stall_needs_out, o_stall, o_valid)

    // empty result buffer cannot stall input next cycle
    `PTS_ASSERT_NEXT(a_empty_no_stall, !o_valid, !o_stall)

    // reset empties both sides
    `PTS_ASSERT_RESET(a_reset_clear, !i_rst_n, !o_valid && !o_stall)

endmodule

bind pan_tilt_servo_smoother pts_checker u_pts_checker (.*);

// File: bench/pan_tilt_servo_smoother_tb.sv
`timescale 1ns / 100ps
// self-checking bench for pan_tilt_servo_smoother: directed table, then random traffic
// under several register settings; needs pts_pkg and the block's rtl only

module pan_tilt_servo_smoother_tb;

    // command codes the block ignores
    localparam logic [3:0] CMD_UNUSED_LO = 4'd13;
    localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

    localparam int DIR_ROWS    = 25;
    localparam int DIR_SPLIT   = 20;
    localparam int SEGMENTS    = 6;
    localparam int SEG_ITEMS   = 100;
    localparam int HOLD_CYCLES = 60;
    localparam int CYCLE_LIMIT = 200000;

    // register settings used by the phases
    typedef enum int {
        PLAN_RESET,
        PLAN_WIDE,
        PLAN_ZERO,
        PLAN_EMPTY_TILT,
        PLAN_RANDOM
    } t_plan;

    // one directed stimulus row
    typedef struct packed {
        logic [3:0]       cmd;
        logic [7:0]       angle;
        logic             lit;
        pts_pkg::t_result res;
    } t_row;

    logic              i_clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    pts_pkg::t_cfg_reg cfg_index = pts_pkg::REG_PAN_LIMIT;
    logic [8:0]        cfg_data = 9'd0;
    logic              in_valid = 1'b0;
    logic [3:0]        in_cmd = 4'd0;
    logic [7:0]        in_angle = 8'd0;
    logic              in_lit = 1'b0;
    pts_pkg::t_result  in_lit_res = '0;
    logic              out_stall = 1'b0;

    logic        o_stall, o_valid;
    logic [7:0]  o_pan_target, o_tilt_target, o_step_now, o_pan_home, o_tilt_home;
    logic [7:0]  o_pan_drive, o_tilt_drive;
    logic        o_drive_valid;

    // idle rates and the long receiver hold-off
    int          snd_idle_pct = 0;
    int          rcv_idle_pct = 0;
    logic        hold_req = 1'b0;
    logic        hold_ack = 1'b0;
    int          hold_left = 0;

    int          cycle_cnt = 0;
    int          err_cnt = 0;
    int          items_in = 0;
    int          results_out = 0;
    int          ticks_in = 0;
    int          stall_cycles = 0;

    logic [8:0]       cfg_plan [8];
    t_row             dir_rows [DIR_ROWS];
    pts_pkg::t_result servo_expect_q [$];

    // predictor copy of configuration
    logic [7:0]  cfg_pan_max, cfg_tilt_min, cfg_tilt_max, cfg_step_min, cfg_step_max;
    logic [7:0]  cfg_centre;
    logic [8:0]  cfg_w_new, cfg_w_old;

    // predictor copy of state
    logic [7:0]  pan_aim, tilt_aim, step_cur, pan_park, tilt_park;
    logic [15:0] pan_filt, tilt_filt;

    pan_tilt_servo_smoother dut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_valid       (in_valid),
        .o_stall       (o_stall),
        .i_cmd         (in_cmd),
        .i_angle       (in_angle),
        .o_valid       (o_valid),
        .i_stall       (out_stall),
        .o_pan_target  (o_pan_target),
        .o_tilt_target (o_tilt_target),
        .o_step_now    (o_step_now),
        .o_pan_home    (o_pan_home),
        .o_tilt_home   (o_tilt_home),
        .o_pan_drive   (o_pan_drive),
        .o_tilt_drive  (o_tilt_drive),
        .o_drive_valid (o_drive_valid)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic void servo_reset();
        cfg_pan_max  = pts_pkg::RESET_PAN_LIMIT;
        cfg_tilt_min = pts_pkg::RESET_TILT_LOW;
        cfg_tilt_max = pts_pkg::RESET_TILT_HIGH;
        cfg_step_min = pts_pkg::RESET_STEP_LOW;
        cfg_step_max = pts_pkg::RESET_STEP_HIGH;
        cfg_centre   = pts_pkg::RESET_CENTRE;
        cfg_w_new    = pts_pkg::RESET_NEW_WEIGHT;
        cfg_w_old    = pts_pkg::RESET_OLD_WEIGHT;
        pan_aim      = 8'd90;
        tilt_aim     = 8'd90;
        pan_filt     = 16'd23040;
        tilt_filt    = 16'd23040;
        step_cur     = pts_pkg::START_STEP;
        pan_park     = 8'd90;
        tilt_park    = 8'd90;
    endfunction

    function automatic void try_pan(input logic [7:0] v);
        if (v <= cfg_pan_max) pan_aim = v;
    endfunction

    function automatic void try_tilt(input logic [7:0] v);
        if (v >= cfg_tilt_min && v <= cfg_tilt_max) tilt_aim = v;
    endfunction

    // q8.8 filter step, rounded half up, clipped to 16 bits
    function automatic logic [15:0] filter_update(input logic [7:0] aim, input logic [15:0] s);
        logic [31:0] acc;
        acc = {24'd0, aim} * 32'd256 * {23'd0, cfg_w_new}
            + {16'd0, s} * {23'd0, cfg_w_old} + 32'd128;
        acc = acc >> 8;
        return (acc > 32'h0000_FFFF) ? 16'hFFFF : acc[15:0];
    endfunction

    function automatic logic [7:0] round_angle(input logic [15:0] s);
        logic [16:0] r;
        r = ({1'b0, s} + 17'd128) >> 8;
        return (r > 17'd255) ? 8'hFF : r[7:0];
    endfunction

    function automatic pts_pkg::t_result servo_next(input logic [3:0] c, input logic [7:0] a);
        pts_pkg::t_result r;
        r = '0;
        case (c)
            pts_pkg::CMD_TICK: begin
                pan_filt  = filter_update(pan_aim, pan_filt);
                tilt_filt = filter_update(tilt_aim, tilt_filt);
                r.drive_valid = 1'b1;
            end
            pts_pkg::CMD_SET_PAN:    try_pan(a);
            pts_pkg::CMD_SET_TILT:   try_tilt(a);
            pts_pkg::CMD_SET_BOTH: begin
                try_pan(a);
                try_tilt(a);
            end
            // targets wrap at 8 bits before the range check
            pts_pkg::CMD_PAN_UP:     try_pan(pan_aim + step_cur);
            pts_pkg::CMD_PAN_DOWN:   try_pan(pan_aim - step_cur);
            pts_pkg::CMD_TILT_UP:    try_tilt(tilt_aim + step_cur);
            pts_pkg::CMD_TILT_DOWN:  try_tilt(tilt_aim - step_cur);
            pts_pkg::CMD_STEP_UP:
                if (step_cur < cfg_step_max) step_cur = step_cur + 8'd1;
            pts_pkg::CMD_STEP_DOWN:
                if (step_cur > cfg_step_min) step_cur = step_cur - 8'd1;
            pts_pkg::CMD_HOME: begin
                try_pan(pan_park);
                try_tilt(tilt_park);
            end
            pts_pkg::CMD_STORE_HOME: begin
                pan_park  = pan_aim;
                tilt_park = tilt_aim;
            end
            pts_pkg::CMD_REINIT: begin
                pan_filt  = {cfg_centre, 8'h00};
                try_pan(cfg_centre);
                tilt_filt = {cfg_centre, 8'h00};
                try_tilt(cfg_centre);
                step_cur  = pts_pkg::START_STEP;
                pan_park  = cfg_centre;
                tilt_park = cfg_centre;
            end
            default: ;
        endcase
        r.pan_target  = pan_aim;
        r.tilt_target = tilt_aim;
        r.step_now    = step_cur;
        r.pan_home    = pan_park;
        r.tilt_home   = tilt_park;
        r.pan_drive   = round_angle(pan_filt);
        r.tilt_drive  = round_angle(tilt_filt);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    // register writes, accepted transactions and results, all at the edge
    always @(posedge i_clk) begin
        pts_pkg::t_result want;
        pts_pkg::t_result calc;
        if (!rst_n) begin
            servo_reset();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    pts_pkg::REG_PAN_LIMIT:  cfg_pan_max  = cfg_data[7:0];
                    pts_pkg::REG_TILT_LOW:   cfg_tilt_min = cfg_data[7:0];
                    pts_pkg::REG_TILT_HIGH:  cfg_tilt_max = cfg_data[7:0];
                    pts_pkg::REG_STEP_LOW:   cfg_step_min = cfg_data[7:0];
                    pts_pkg::REG_STEP_HIGH:  cfg_step_max = cfg_data[7:0];
                    pts_pkg::REG_CENTRE:     cfg_centre   = cfg_data[7:0];
                    pts_pkg::REG_NEW_WEIGHT: cfg_w_new    = cfg_data;
                    pts_pkg::REG_OLD_WEIGHT: cfg_w_old    = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && o_stall) stall_cycles++;
            if (in_valid && !o_stall) begin
                calc = servo_next(in_cmd, in_angle);
                servo_expect_q.push_back(in_lit ? in_lit_res : calc);
                items_in++;
                if (in_cmd == pts_pkg::CMD_TICK) ticks_in++;
            end
            if (o_valid && !out_stall) begin
                results_out++;
                if (servo_expect_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    err_cnt++;
                end else begin
                    want = servo_expect_q.pop_front();
                    check_field("pan_target", want.pan_target, o_pan_target);
                    check_field("tilt_target", want.tilt_target, o_tilt_target);
                    check_field("step_now", want.step_now, o_step_now);
                    check_field("pan_home", want.pan_home, o_pan_home);
                    check_field("tilt_home", want.tilt_home, o_tilt_home);
                    check_field("pan_drive", want.pan_drive, o_pan_drive);
                    check_field("tilt_drive", want.tilt_drive, o_tilt_drive);
                    check_field("drive_valid", {7'd0, want.drive_valid}, {7'd0, o_drive_valid});
                end
            end
        end
    end

    // ---------------- receiver ----------------

    // random stall, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    // ---------------- sender ----------------

    function automatic t_row lit_row(input logic [3:0] c, input logic [7:0] a,
                                     input logic [7:0] pt, input logic [7:0] tt,
                                     input logic [7:0] sn, input logic [7:0] ph,
                                     input logic [7:0] th, input logic [7:0] pd,
                                     input logic [7:0] td, input logic dv);
        t_row r;
        r.cmd   = c;
        r.angle = a;
        r.lit   = 1'b1;
        r.res   = '{pt, tt, sn, ph, th, pd, td, dv};
        return r;
    endfunction

    function automatic t_row calc_row(input logic [3:0] c, input logic [7:0] a);
        t_row r;
        r       = '0;
        r.cmd   = c;
        r.angle = a;
        return r;
    endfunction

    // one input transaction, with random idle cycles in front
    task automatic offer(input logic [3:0] c, input logic [7:0] a, input logic lit,
                         input pts_pkg::t_result res);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        in_cmd     <= c;
        in_angle   <= a;
        in_lit     <= lit;
        in_lit_res <= res;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // random command, angles often placed around the current range edges
    task automatic offer_random();
        int          r;
        logic [3:0]  c;
        logic [7:0]  a;
        logic [7:0]  base;
        r = $urandom_range(99);
        if (r < 25)      c = pts_pkg::CMD_TICK;
        else if (r < 42) c = 4'(pts_pkg::CMD_SET_PAN + $urandom_range(2));
        else if (r < 62) c = 4'(pts_pkg::CMD_PAN_UP + $urandom_range(3));
        else if (r < 74) c = 4'(pts_pkg::CMD_STEP_UP + $urandom_range(1));
        else if (r < 84) c = 4'(pts_pkg::CMD_HOME + $urandom_range(1));
        else if (r < 89) c = pts_pkg::CMD_REINIT;
        else if (r < 93) c = 4'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
        else             c = pts_pkg::CMD_SET_BOTH;
        if ($urandom_range(1) == 0) begin
            a = 8'($urandom);
        end else begin
            case ($urandom_range(4))
                0:       base = cfg_plan[pts_pkg::REG_PAN_LIMIT][7:0];
                1:       base = cfg_plan[pts_pkg::REG_TILT_LOW][7:0];
                2:       base = cfg_plan[pts_pkg::REG_TILT_HIGH][7:0];
                3:       base = cfg_plan[pts_pkg::REG_CENTRE][7:0];
                default: base = 8'd0;
            endcase
            a = base + 8'($urandom_range(2)) - 8'd1;
        end
        offer(c, a, 1'b0, '0);
    endtask

    // wait until every result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (servo_expect_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic plan_settings(input t_plan kind);
        logic [7:0] lo, hi, t;
        logic [8:0] wn;
        case (kind)
            PLAN_RESET: begin
                cfg_plan[pts_pkg::REG_PAN_LIMIT]  = {1'b0, pts_pkg::RESET_PAN_LIMIT};
                cfg_plan[pts_pkg::REG_TILT_LOW]   = {1'b0, pts_pkg::RESET_TILT_LOW};
                cfg_plan[pts_pkg::REG_TILT_HIGH]  = {1'b0, pts_pkg::RESET_TILT_HIGH};
                cfg_plan[pts_pkg::REG_STEP_LOW]   = {1'b0, pts_pkg::RESET_STEP_LOW};
                cfg_plan[pts_pkg::REG_STEP_HIGH]  = {1'b0, pts_pkg::RESET_STEP_HIGH};
                cfg_plan[pts_pkg::REG_CENTRE]     = {1'b0, pts_pkg::RESET_CENTRE};
                cfg_plan[pts_pkg::REG_NEW_WEIGHT] = pts_pkg::RESET_NEW_WEIGHT;
                cfg_plan[pts_pkg::REG_OLD_WEIGHT] = pts_pkg::RESET_OLD_WEIGHT;
            end
            PLAN_WIDE: begin
                cfg_plan[pts_pkg::REG_PAN_LIMIT]  = 9'd255;
                cfg_plan[pts_pkg::REG_TILT_LOW]   = 9'd0;
                cfg_plan[pts_pkg::REG_TILT_HIGH]  = 9'd255;
                cfg_plan[pts_pkg::REG_STEP_LOW]   = 9'd0;
                cfg_plan[pts_pkg::REG_STEP_HIGH]  = 9'd255;
                cfg_plan[pts_pkg::REG_CENTRE]     = 9'd255;
                cfg_plan[pts_pkg::REG_NEW_WEIGHT] = 9'd256;
                cfg_plan[pts_pkg::REG_OLD_WEIGHT] = 9'd511;
            end
            PLAN_ZERO: begin
                for (int i = 0; i < 8; i++) cfg_plan[i] = 9'd0;
            end
            PLAN_EMPTY_TILT: begin
                cfg_plan[pts_pkg::REG_PAN_LIMIT]  = 9'd255;
                cfg_plan[pts_pkg::REG_TILT_LOW]   = 9'd200;
                cfg_plan[pts_pkg::REG_TILT_HIGH]  = 9'd100;
                cfg_plan[pts_pkg::REG_STEP_LOW]   = 9'd0;
                cfg_plan[pts_pkg::REG_STEP_HIGH]  = 9'd255;
                cfg_plan[pts_pkg::REG_CENTRE]     = 9'd255;
                cfg_plan[pts_pkg::REG_NEW_WEIGHT] = 9'd511;
                cfg_plan[pts_pkg::REG_OLD_WEIGHT] = 9'd511;
            end
            default: begin
                lo = 8'($urandom_range(200));
                hi = 8'($urandom_range(255, lo));
                // now and then an empty tilt range
                if ($urandom_range(4) == 0) begin
                    t  = lo;
                    lo = hi;
                    hi = t;
                end
                // 8-bit registers get a random ninth bit, which must be ignored
                cfg_plan[pts_pkg::REG_PAN_LIMIT] = {1'($urandom_range(1)), 8'($urandom)};
                cfg_plan[pts_pkg::REG_TILT_LOW]  = {1'($urandom_range(1)), lo};
                cfg_plan[pts_pkg::REG_TILT_HIGH] = {1'($urandom_range(1)), hi};
                t = 8'($urandom_range(5));
                cfg_plan[pts_pkg::REG_STEP_LOW]  = {1'($urandom_range(1)), t};
                cfg_plan[pts_pkg::REG_STEP_HIGH] = {1'($urandom_range(1)),
                                                    8'($urandom_range(20, t))};
                cfg_plan[pts_pkg::REG_CENTRE]    = {1'($urandom_range(1)), 8'($urandom)};
                wn = 9'($urandom_range(256));
                cfg_plan[pts_pkg::REG_NEW_WEIGHT] = wn;
                cfg_plan[pts_pkg::REG_OLD_WEIGHT] = 9'd256 - wn;
                if ($urandom_range(3) == 0) begin
                    cfg_plan[pts_pkg::REG_NEW_WEIGHT] = 9'($urandom_range(511));
                    cfg_plan[pts_pkg::REG_OLD_WEIGHT] = 9'($urandom_range(511));
                end
            end
        endcase
    endtask

    // write all registers from the plan while the block is idle
    task automatic load_cfg();
        drain();
        for (int i = 0; i < 8; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= pts_pkg::t_cfg_reg'(i);
            cfg_data  <= cfg_plan[i];
            @(posedge i_clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // ---------------- main sequence ----------------

    initial begin
        servo_reset();
        plan_settings(PLAN_RESET);

        // reset settings: targets, range edges, wrap, step floor, homes
        dir_rows[0]  = lit_row(pts_pkg::CMD_TICK, 8'd0, 90, 90, 1, 90, 90, 90, 90, 1'b1);
        dir_rows[1]  = lit_row(pts_pkg::CMD_SET_PAN, 8'd180, 180, 90, 1, 90, 90, 90, 90, 1'b0);
        dir_rows[2]  = lit_row(pts_pkg::CMD_SET_PAN, 8'd181, 180, 90, 1, 90, 90, 90, 90, 1'b0);
        dir_rows[3]  = lit_row(pts_pkg::CMD_SET_TILT, 8'd0, 180, 0, 1, 90, 90, 90, 90, 1'b0);
        dir_rows[4]  = lit_row(pts_pkg::CMD_SET_TILT, 8'd255, 180, 0, 1, 90, 90, 90, 90, 1'b0);
        dir_rows[5]  = lit_row(pts_pkg::CMD_SET_BOTH, 8'd255, 180, 0, 1, 90, 90, 90, 90, 1'b0);
        dir_rows[6]  = lit_row(pts_pkg::CMD_SET_BOTH, 8'd0, 0, 0, 1, 90, 90, 90, 90, 1'b0);
        dir_rows[7]  = lit_row(pts_pkg::CMD_PAN_DOWN, 8'd0, 0, 0, 1, 90, 90, 90, 90, 1'b0);
        dir_rows[8]  = lit_row(pts_pkg::CMD_TILT_DOWN, 8'd0, 0, 0, 1, 90, 90, 90, 90, 1'b0);
        dir_rows[9]  = lit_row(pts_pkg::CMD_PAN_UP, 8'd0, 1, 0, 1, 90, 90, 90, 90, 1'b0);
        dir_rows[10] = lit_row(pts_pkg::CMD_TILT_UP, 8'd0, 1, 1, 1, 90, 90, 90, 90, 1'b0);
        dir_rows[11] = lit_row(pts_pkg::CMD_STEP_DOWN, 8'd0, 1, 1, 1, 90, 90, 90, 90, 1'b0);
        dir_rows[12] = calc_row(pts_pkg::CMD_STEP_UP, 8'd0);
        dir_rows[13] = calc_row(pts_pkg::CMD_STORE_HOME, 8'd0);
        dir_rows[14] = calc_row(pts_pkg::CMD_SET_BOTH, 8'd170);
        dir_rows[15] = calc_row(pts_pkg::CMD_HOME, 8'd0);
        dir_rows[16] = calc_row(pts_pkg::CMD_TICK, 8'd0);
        dir_rows[17] = lit_row(pts_pkg::CMD_REINIT, 8'd0, 90, 90, 1, 90, 90, 90, 90, 1'b0);
        dir_rows[18] = lit_row(CMD_UNUSED_LO, 8'hAA, 90, 90, 1, 90, 90, 90, 90, 1'b0);
        dir_rows[19] = lit_row(CMD_UNUSED_HI, 8'hFF, 90, 90, 1, 90, 90, 90, 90, 1'b0);
        // empty tilt range, widest pan and step, oversized weights
        dir_rows[20] = lit_row(pts_pkg::CMD_REINIT, 8'd0, 255, 90, 1, 255, 255, 255, 255, 1'b0);
        dir_rows[21] = lit_row(pts_pkg::CMD_TICK, 8'd0, 255, 90, 1, 255, 255, 255, 255, 1'b1);
        dir_rows[22] = lit_row(pts_pkg::CMD_STEP_DOWN, 8'd0, 255, 90, 0, 255, 255, 255, 255,
                               1'b0);
        dir_rows[23] = lit_row(pts_pkg::CMD_PAN_UP, 8'd0, 255, 90, 0, 255, 255, 255, 255, 1'b0);
        dir_rows[24] = lit_row(pts_pkg::CMD_SET_TILT, 8'd150, 255, 90, 0, 255, 255, 255, 255,
                               1'b0);

        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (i == DIR_SPLIT) begin
                plan_settings(PLAN_EMPTY_TILT);
                load_cfg();
            end
            offer(dir_rows[i].cmd, dir_rows[i].angle, dir_rows[i].lit, dir_rows[i].res);
        end

        // random traffic: receiver-idle pair, sender-idle pair, then no idling
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0:       plan_settings(PLAN_RESET);
                1:       plan_settings(PLAN_WIDE);
                3:       plan_settings(PLAN_ZERO);
                default: plan_settings(PLAN_RANDOM);
            endcase
            load_cfg();
            case (seg / 2)
                0: begin
                    snd_idle_pct <= 17;
                    rcv_idle_pct <= 87;
                end
                1: begin
                    snd_idle_pct <= 87;
                    rcv_idle_pct <= 17;
                end
                default: begin
                    snd_idle_pct <= 0;
                    rcv_idle_pct <= 0;
                end
            endcase
            // long receiver hold-off while the sender keeps pushing
            if (seg == SEGMENTS - 1) hold_req <= ~hold_req;
            repeat (SEG_ITEMS) offer_random();
        end

        drain();
        repeat (8) @(posedge i_clk);

        $display("%0d input transactions (%0d ticks), %0d results checked, input stalled %0d cycles",
                 items_in, ticks_in, results_out, stall_cycles);
        $display("settings: reset, wide, empty tilt, all zero and random; %0d mismatches", err_cnt);
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
